/* rtl/mdtw_pkg.sv */
// Shared types and constants for the MIDI delta-time event writer.
`timescale 1ns / 1ps

package mdtw_pkg;

  // Variable-length quantity layout: seven value bits per byte, top bit continues.
  localparam int VLQ_BITS = 7;
  localparam logic [6:0] VLQ_MASK = 7'h7F;
  localparam logic [7:0] VLQ_CONT = 8'h80;
  localparam int MAX_DIGITS = 5;
  localparam int DIGIT_CNT_W = 3;

  // Item kinds carried on the input user field.
  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_SET_CLOCK = 1'b1;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // One input word, unpacked from the stream bus.
  typedef struct packed {
    logic       kind;
    logic [2:0] stream;
    logic [31:0] event_time;
    logic [7:0] cmd_byte;
    logic       first_of_cmd;
    logic       last_of_cmd;
  } mdtw_item_t;

  // One classified word waiting to be written out by the back end.
  typedef struct packed {
    logic [31:0]            delta;
    logic [DIGIT_CNT_W-1:0] ndig;
    logic [7:0]             cmd_byte;
    logic [2:0]             stream;
    logic                   last_of_cmd;
  } mdtw_entry_t;

endpackage

/* rtl/mdtw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mdtw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/mdtw_front.sv */
// Front end: looks up the stream clock, works out the delta and classifies each word.
`timescale 1ns / 1ps

module mdtw_front #(
  parameter int NUM_STREAMS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mdtw_pkg::mdtw_item_t in_item,
  output logic               push,
  output mdtw_pkg::mdtw_entry_t push_entry,
  input  logic               q_full
);
  import mdtw_pkg::*;

  localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int unsigned NS_U = NUM_STREAMS;

  // Word held while its stream clock is read.
  logic       s1_valid;
  mdtw_item_t s1;

  // Clock store with one valid bit per stream, plus the most recent write for forwarding.
  logic [NUM_STREAMS-1:0] clk_valid;
  logic                   lw_valid;
  logic [AW-1:0]          lw_addr;
  logic [31:0]            lw_data;
  logic [31:0]            rdata;
  logic                   dropping;

  logic          accept;
  logic          in_range_in;
  logic          s1_in_range;
  logic [AW-1:0] s1_addr;
  logic [31:0]   clock_cur;
  logic          late;
  logic [31:0]   delta;
  logic [DIGIT_CNT_W-1:0] ndig;
  logic          s1_push;
  logic          s1_write;
  logic          go;

  assign in_range_in = 32'(in_item.stream) < NS_U;
  assign s1_in_range = 32'(s1.stream) < NS_U;
  assign s1_addr     = AW'(s1.stream);

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid || go;

  mdtw_ram #(
    .WIDTH (32),
    .DEPTH (NUM_STREAMS),
    .AW    (AW)
  ) u_clock_ram (
    .clk   (clk),
    .we    (go && s1_write),
    .waddr (s1_addr),
    .wdata (s1.event_time),
    .re    (accept && in_range_in),
    .raddr (AW'(in_item.stream)),
    .rdata (rdata)
  );

  // Current clock of the word's stream: the latest write wins, an unwritten entry reads zero.
  always_comb begin
    if (lw_valid && (lw_addr == s1_addr)) begin
      clock_cur = lw_data;
    end else if (clk_valid[s1_addr]) begin
      clock_cur = rdata;
    end else begin
      clock_cur = '0;
    end
  end

  assign late  = s1.event_time < clock_cur;
  assign delta = s1.event_time - clock_cur;

  // Number of seven-bit groups needed for the delta.
  always_comb begin
    if (delta[31:28] != 4'd0) begin
      ndig = DIGIT_CNT_W'(MAX_DIGITS);
    end else if (delta[27:21] != 7'd0) begin
      ndig = DIGIT_CNT_W'(4);
    end else if (delta[20:14] != 7'd0) begin
      ndig = DIGIT_CNT_W'(3);
    end else if (delta[13:7] != 7'd0) begin
      ndig = DIGIT_CNT_W'(2);
    end else begin
      ndig = DIGIT_CNT_W'(1);
    end
  end

  // Classification of the held word.
  assign s1_push  = s1_valid && s1_in_range && (s1.kind == KIND_CMD) &&
                    (s1.first_of_cmd ? !late : !dropping);
  assign s1_write = s1_valid && s1_in_range &&
                    ((s1.kind == KIND_SET_CLOCK) || (s1.first_of_cmd && !late));
  assign go       = s1_valid && (!s1_push || !q_full);
  assign push     = go && s1_push;

  always_comb begin
    push_entry.delta       = delta;
    push_entry.ndig        = s1.first_of_cmd ? ndig : '0;
    push_entry.cmd_byte    = s1.cmd_byte;
    push_entry.stream      = s1.stream;
    push_entry.last_of_cmd = s1.last_of_cmd;
  end

  // Control state: held word, clock valid bits and the dropping flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      clk_valid <= '0;
      lw_valid  <= 1'b0;
      dropping  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      if (go && s1_write) begin
        clk_valid[s1_addr] <= 1'b1;
        lw_valid           <= 1'b1;
      end
      if (go && s1_in_range && (s1.kind == KIND_CMD) && s1.first_of_cmd) begin
        dropping <= late;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_item;
    end
    if (go && s1_write) begin
      lw_addr <= s1_addr;
      lw_data <= s1.event_time;
    end
  end

endmodule

/* rtl/mdtw_queue.sv */
// Short queue of classified words between the front and back end.
`timescale 1ns / 1ps

module mdtw_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mdtw_pkg::mdtw_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  out_valid,
  output mdtw_pkg::mdtw_entry_t out_entry
);
  import mdtw_pkg::*;

  mdtw_entry_t      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_entry = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

/* rtl/mdtw_back.sv */
// Back end: writes the delta groups most significant first, then the command byte.
`timescale 1ns / 1ps

module mdtw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  mdtw_pkg::mdtw_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic [2:0]            out_stream,
  output logic                  out_last,
  output logic                  out_eoe
);
  import mdtw_pkg::*;

  logic                   cur_valid;
  mdtw_entry_t            cur;
  logic [DIGIT_CNT_W-1:0] cur_idx;

  logic       advance;
  logic       on_cmd;
  logic [6:0] digit;
  logic [7:0] byte_sel;

  assign on_cmd  = cur_idx == '0;
  assign advance = cur_valid && (!out_valid || out_ready);
  assign q_pop   = q_valid && (!cur_valid || (advance && on_cmd));

  // Pick the group that the countdown points at.
  always_comb begin
    case (cur_idx)
      DIGIT_CNT_W'(1): digit = cur.delta[6:0];
      DIGIT_CNT_W'(2): digit = cur.delta[13:7];
      DIGIT_CNT_W'(3): digit = cur.delta[20:14];
      DIGIT_CNT_W'(4): digit = cur.delta[27:21];
      DIGIT_CNT_W'(5): digit = {3'd0, cur.delta[31:28]};
      default:         digit = '0;
    endcase
  end

  // Every group but the last carries the continuation bit.
  always_comb begin
    if (on_cmd) begin
      byte_sel = cur.cmd_byte;
    end else if (cur_idx != DIGIT_CNT_W'(1)) begin
      byte_sel = VLQ_CONT | {1'b0, digit & VLQ_MASK};
    end else begin
      byte_sel = {1'b0, digit & VLQ_MASK};
    end
  end

  // Control: current entry, its countdown and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (advance && on_cmd) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // Payload: entry, countdown and the output word.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_entry;
      cur_idx <= q_entry.ndig;
    end else if (advance && !on_cmd) begin
      cur_idx <= cur_idx - 1'b1;
    end
    if (advance) begin
      out_byte   <= byte_sel;
      out_stream <= cur.stream;
      out_last   <= on_cmd;
      out_eoe    <= on_cmd && cur.last_of_cmd;
    end
  end

endmodule

/* rtl/midi_delta_time_event_writer.sv */
// Top level of the MIDI delta-time event writer. Each input word is either a command byte
// or a set-clock word for one of NUM_STREAMS streams. The first byte of a command is
// written as its delta from the stream clock, a big-endian variable-length quantity of one
// to five bytes, followed by the byte itself; later bytes pass straight through, and a
// command that starts before its stream clock is dropped whole. The input takes one word
// per cycle unless the queue is full; a first byte makes two to six output words, so the
// sustained rate is set by the back end, which writes one output word per cycle from its
// output register while m_tready is high. The front end reads the stream clock from a
// small RAM in the cycle after acceptance and forwards the newest write, and a four-entry
// queue lets the input keep flowing while the back end writes delta bytes. Stream clocks
// read as zero after reset through one valid bit per stream, so there is no clearing pass.
`timescale 1ns / 1ps

module midi_delta_time_event_writer #(
  parameter int NUM_STREAMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // stream[2:0], event_time[34:3], cmd_byte[42:35], first_of_cmd[43], zero fill [47:44]
  input  logic [47:0] s_tdata,
  // kind[0]
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte[7:0], out_stream[10:8], zero fill [15:11]
  output logic [15:0] m_tdata,
  // end_of_event[0]
  output logic        m_tuser,
  output logic        m_tlast
);
  import mdtw_pkg::*;

  mdtw_item_t  in_item;
  mdtw_entry_t push_entry;
  mdtw_entry_t q_entry;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic [7:0]  out_byte;
  logic [2:0]  out_stream;

  // Unpack the input word.
  always_comb begin
    in_item.kind         = s_tuser;
    in_item.stream       = s_tdata[2:0];
    in_item.event_time   = s_tdata[34:3];
    in_item.cmd_byte     = s_tdata[42:35];
    in_item.first_of_cmd = s_tdata[43];
    in_item.last_of_cmd  = s_tlast;
  end

  mdtw_front #(
    .NUM_STREAMS (NUM_STREAMS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  mdtw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .out_valid  (q_valid),
    .out_entry  (q_entry)
  );

  mdtw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (out_byte),
    .out_stream (out_stream),
    .out_last   (m_tlast),
    .out_eoe    (m_tuser)
  );

  // Pack the output word.
  assign m_tdata = {5'd0, out_stream, out_byte};

  // The input only stalls when the queue is full.
  a_stall_on_full : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_full)
    else $error("input stalled while the queue had room");

  // A taken delta byte is always followed at once by a valid word, the next of its run.
  a_run_unbroken : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("gap inside a delta-time run");

  // End of event only ever marks the command byte closing a run.
  a_eoe_on_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("end of event on a delta byte");

endmodule

/* tb/mdtw_checker.sv */
// Scoreboard for the MIDI delta-time event writer: predicts track words and compares them.
`timescale 1ns / 1ps

module mdtw_checker #(
  parameter int NUM_STREAMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // stream[2:0], event_time[34:3], cmd_byte[42:35], first_of_cmd[43], zero fill [47:44]
  input  logic [47:0] s_tdata,
  // kind[0]
  input  logic        s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // out_byte[7:0], out_stream[10:8], zero fill [15:11]
  input  logic [15:0] m_tdata,
  // end_of_event[0]
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);
  import mdtw_pkg::*;

  // One track word as it should leave the block.
  typedef struct packed {
    logic [7:0] track_byte;
    logic [2:0] strm;
    logic       run_end;
    logic       cmd_end;
  } track_word_t;

  track_word_t expected_words[$];
  logic [31:0] out_clock [NUM_STREAMS];
  logic        skipping_cmd;

  // Works out the track words caused by one accepted input word.
  task automatic predict_track_words(input mdtw_item_t it);
    logic [31:0] delta;
    int          ndig;
    track_word_t w;
    if (int'(it.stream) >= NUM_STREAMS) return;
    if (it.kind == KIND_SET_CLOCK) begin
      out_clock[it.stream] = it.event_time;
      return;
    end
    // Later bytes of a command pass through unless the command is being skipped.
    if (!it.first_of_cmd) begin
      if (!skipping_cmd) begin
        w = '{it.cmd_byte, it.stream, 1'b1, it.last_of_cmd};
        expected_words.push_back(w);
      end
      return;
    end
    // A command that starts before its stream clock is skipped whole.
    if (it.event_time < out_clock[it.stream]) begin
      skipping_cmd = 1'b1;
      return;
    end
    skipping_cmd = 1'b0;
    delta = it.event_time - out_clock[it.stream];
    out_clock[it.stream] = it.event_time;
    ndig = 1;
    while (ndig < MAX_DIGITS && (delta >> (VLQ_BITS * ndig)) != 0) ndig++;
    // Most significant group first; every group but the last carries the continuation bit.
    for (int k = ndig - 1; k >= 0; k--) begin
      w.track_byte = 8'((delta >> (VLQ_BITS * k)) & 32'(VLQ_MASK));
      if (k != 0) w.track_byte = w.track_byte | VLQ_CONT;
      w.strm = it.stream;
      w.run_end = 1'b0;
      w.cmd_end = 1'b0;
      expected_words.push_back(w);
    end
    w = '{it.cmd_byte, it.stream, 1'b1, it.last_of_cmd};
    expected_words.push_back(w);
  endtask

  // Compare output words first, then add the predictions for this edge's input word.
  always @(posedge clk) begin : monitor
    track_word_t got;
    track_word_t want;
    mdtw_item_t  item;
    if (rst) begin
      expected_words.delete();
      for (int i = 0; i < NUM_STREAMS; i++) out_clock[i] = '0;
      skipping_cmd = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tdata[10:8], m_tlast, m_tuser};
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected word byte=%h stream=%0d last=%b eoe=%b", $realtime,
                     got.track_byte, got.strm, got.run_end, got.cmd_end);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch expected byte=%h stream=%0d last=%b eoe=%b",
                       $realtime, want.track_byte, want.strm, want.run_end, want.cmd_end);
              $display("%0t:          got byte=%h stream=%0d last=%b eoe=%b",
                       $realtime, got.track_byte, got.strm, got.run_end, got.cmd_end);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        item.kind = s_tuser;
        item.stream = s_tdata[2:0];
        item.event_time = s_tdata[34:3];
        item.cmd_byte = s_tdata[42:35];
        item.first_of_cmd = s_tdata[43];
        item.last_of_cmd = s_tlast;
        predict_track_words(item);
      end
    end
    pending = expected_words.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the MIDI delta-time event writer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import mdtw_pkg::*;

  localparam int NUM_STREAMS = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int          errors;
  int          pending;

  // Idling controls for the sender and the receiver.
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          long_hold_cycles = 0;
  int          hold_left = 0;

  // Stream clocks as the stimulus believes them to be, to shape well-formed commands.
  logic [31:0] shadow_clock [NUM_STREAMS];

  midi_delta_time_event_writer #(.NUM_STREAMS(NUM_STREAMS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  mdtw_checker #(.NUM_STREAMS(NUM_STREAMS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .errors(errors), .pending(pending)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, with an occasional long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_cycles > 0) begin
        hold_left = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offers one input word, with random idle cycles before it, and waits for acceptance.
  task automatic send_word(input logic kind, input logic [2:0] strm, input logic [31:0] t,
                           input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tlast <= last;
    s_tdata <= {4'b0000, first, b, t, strm};
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_SET_CLOCK || (first && t >= shadow_clock[strm])) shadow_clock[strm] = t;
    @(negedge clk);
  endtask

  // One command: a first byte followed by len-1 later bytes.
  task automatic send_command(input logic [2:0] strm, input logic [31:0] t, input int len);
    logic last;
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0);
      send_word(KIND_CMD, strm, (i == 0) ? t : $urandom, 8'($urandom), i == 0, last);
    end
  endtask

  // Holds the sender off until every predicted word has left the block.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Delta of random bit length, so that every quantity size turns up.
  function automatic logic [31:0] random_delta();
    int nb;
    nb = $urandom_range(32, 0);
    if (nb == 0) return '0;
    if (nb == 32) return $urandom;
    return $urandom & ((32'h1 << nb) - 1);
  endfunction

  // Mostly well-formed commands with random content, plus clock loads, late commands and noise.
  task automatic random_traffic(input int n);
    int          sent;
    int          r;
    int          len;
    logic [2:0]  strm;
    logic [31:0] t;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      strm = 3'($urandom_range(NUM_STREAMS - 1));
      len = $urandom_range(4, 1);
      if (r < 8) begin
        t = $urandom >> $urandom_range(31, 0);
        send_word(KIND_SET_CLOCK, strm, t, 8'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else if (r < 13) begin
        send_word(KIND_CMD, strm, $urandom, 8'($urandom), 1'b0, 1'($urandom));
        sent++;
      end else if (r < 20) begin
        t = shadow_clock[strm] - 32'd1 - 32'($urandom_range(5000));
        send_command(strm, t, len);
        sent += len;
      end else begin
        t = shadow_clock[strm] + random_delta();
        send_command(strm, t, len);
        sent += len;
      end
    end
  endtask

  // Stimulus.
  initial begin
    for (int i = 0; i < NUM_STREAMS; i++) shadow_clock[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with no idling.
    // A later byte with no command since reset passes through.
    send_word(KIND_CMD, 3'd0, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1);
    // Zero delta with a three-byte command, then one- and two-byte quantity edges.
    send_word(KIND_CMD, 3'd0, 32'd0, 8'h90, 1'b1, 1'b0);
    send_word(KIND_CMD, 3'd0, 32'd0, 8'h3C, 1'b0, 1'b0);
    send_word(KIND_CMD, 3'd0, 32'd0, 8'hFF, 1'b0, 1'b1);
    send_word(KIND_CMD, 3'd0, 32'd127, 8'hFF, 1'b1, 1'b1);
    send_word(KIND_CMD, 3'd0, 32'd255, 8'h80, 1'b1, 1'b0);
    // Quantity size boundaries, each from a clock loaded with zero.
    begin : size_edges
      logic [31:0] edges [7];
      edges = '{32'd16383, 32'd16384, 32'd2097151, 32'd2097152,
                32'd268435455, 32'd268435456, 32'hFFFF_FFFF};
      for (int i = 0; i < 7; i++) begin
        send_word(KIND_SET_CLOCK, 3'(i), 32'd0, 8'h00, 1'b0, 1'b0);
        send_word(KIND_CMD, 3'(i), edges[i], 8'($urandom), 1'b1, 1'b1);
      end
    end
    // Late command: skipped with its later bytes, even across a clock load.
    send_word(KIND_SET_CLOCK, 3'd7, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
    send_word(KIND_CMD, 3'd7, 32'hFFFF_FFFE, 8'h90, 1'b1, 1'b0);
    send_word(KIND_CMD, 3'd7, 32'd0, 8'h40, 1'b0, 1'b0);
    send_word(KIND_SET_CLOCK, 3'd3, 32'd1000, 8'h00, 1'b0, 1'b0);
    send_word(KIND_CMD, 3'd2, 32'd0, 8'h7F, 1'b0, 1'b1);
    send_word(KIND_CMD, 3'd7, 32'hFFFF_FFFF, 8'hB0, 1'b1, 1'b1);
    wait_drained();

    // No idling, with one long receiver hold-off while the sender keeps offering.
    long_hold_cycles = 300;
    random_traffic(64);
    wait_drained();

    // Sender idle in about half of the cycles.
    tx_idle_pct = 54;
    rx_stall_pct = 0;
    random_traffic(64);
    wait_drained();

    // Receiver stalling in about half of the cycles.
    tx_idle_pct = 0;
    rx_stall_pct = 54;
    random_traffic(64);
    wait_drained();

    // Light idling on both sides.
    tx_idle_pct = 9;
    rx_stall_pct = 9;
    random_traffic(64);

    // Drain and let the pipeline settle.
    s_tvalid <= 1'b0;
    rx_stall_pct = 0;
    begin : drain
      int waited;
      waited = 0;
      @(negedge clk);
      while (pending != 0 && waited < 50000) begin
        @(negedge clk);
        waited++;
      end
    end
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
